// File: design/tfst_pkg.sv
// ----------------------------------------------------------------------------
// tfst_pkg
// Shared types and constants for the TCP flow statistics table: table size,
// result status codes, controller states and the command/status bundles
// between controller and datapath.
// ----------------------------------------------------------------------------
package tfst_pkg;

  // Table geometry
  localparam int FLOW_ENTRIES = 64;
  localparam int IDX_W        = $clog2(FLOW_ENTRIES);
  localparam int CNT_W        = $clog2(FLOW_ENTRIES + 1);

  // Field widths
  localparam int PROTO_W = 8;
  localparam int IP_W    = 32;
  localparam int PORT_W  = 16;
  localparam int LEN_W   = 16;
  localparam int CTR_W   = 32;

  localparam logic [PROTO_W-1:0] PROTO_RESET = 8'd6;  // TCP

  // Actions
  localparam logic ACT_COUNT = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_IGNORED    = 3'd0,
    ST_HIT        = 3'd1,
    ST_NEW        = 3'd2,
    ST_FULL       = 3'd3,
    ST_READ_OK    = 3'd4,
    ST_READ_EMPTY = 3'd5
  } status_e;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SEARCH,
    S_HIT,
    S_MISS,
    S_READ
  } state_e;

  typedef struct packed {
    logic [IP_W-1:0]   sip;
    logic [IP_W-1:0]   dip;
    logic [PORT_W-1:0] sport;
    logic [PORT_W-1:0] dport;
  } key_t;

  typedef struct packed {
    key_t             key;
    logic [CTR_W-1:0] pkt;
    logic [CTR_W-1:0] byt;
  } entry_t;

  // Controller -> datapath
  typedef struct packed {
    logic    load_in;      // capture input transfer, clear scan address
    logic    rd_en;        // table read, data registered next cycle
    logic    rd_sel_ridx;  // read at read_index instead of scan address
    logic    wr_hit;       // write updated counters of matched entry
    logic    wr_new;       // allocate next free entry
    logic    res_ld;       // load output register
    status_e res_sel;      // which result to form
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic act_read;     // captured action is a read
    logic proto_match;  // captured protocol equals counted protocol
    logic ridx_valid;   // read index below fill count
    logic scan_end;     // scan address reached fill count
    logic key_match;    // registered entry key equals captured key
    logic full;         // no free entry left
    logic out_free;     // output register can take a result
  } status_t;

endpackage

// File: design/tfst_ctrl.sv
// ----------------------------------------------------------------------------
// tfst_ctrl
// Controller of the flow table: sequences decode, linear key search over the
// used entries, counter update or allocation, and table reads.
// ----------------------------------------------------------------------------
module tfst_ctrl import tfst_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t sts_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   cmp_v_q, cmp_v_d;  // registered read data holds a scanned entry

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmp_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cmp_v_q <= cmp_v_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d           = state_q;
    cmp_v_d           = 1'b0;
    cmd_o             = '0;
    cmd_o.res_sel     = ST_IGNORED;
    in_stall_o        = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.act_read) begin
          if (sts_i.ridx_valid) begin
            cmd_o.rd_en       = 1'b1;
            cmd_o.rd_sel_ridx = 1'b1;
            state_d           = S_READ;
          end else if (sts_i.out_free) begin
            cmd_o.res_ld  = 1'b1;
            cmd_o.res_sel = ST_READ_EMPTY;
            state_d       = S_IDLE;
          end
        end else if (!sts_i.proto_match) begin
          if (sts_i.out_free) begin
            cmd_o.res_ld  = 1'b1;
            cmd_o.res_sel = ST_IGNORED;
            state_d       = S_IDLE;
          end
        end else begin
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        // compare previous read, issue next one
        if (cmp_v_q && sts_i.key_match) begin
          state_d = S_HIT;
        end else if (!sts_i.scan_end) begin
          cmd_o.rd_en = 1'b1;
          cmp_v_d     = 1'b1;
        end else begin
          state_d = S_MISS;
        end
      end
      S_HIT: begin
        if (sts_i.out_free) begin
          cmd_o.wr_hit  = 1'b1;
          cmd_o.res_ld  = 1'b1;
          cmd_o.res_sel = ST_HIT;
          state_d       = S_IDLE;
        end
      end
      S_MISS: begin
        if (sts_i.out_free) begin
          cmd_o.res_ld = 1'b1;
          if (sts_i.full) begin
            cmd_o.res_sel = ST_FULL;
          end else begin
            cmd_o.wr_new  = 1'b1;
            cmd_o.res_sel = ST_NEW;
          end
          state_d = S_IDLE;
        end
      end
      S_READ: begin
        if (sts_i.out_free) begin
          cmd_o.res_ld  = 1'b1;
          cmd_o.res_sel = ST_READ_OK;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// File: design/tfst_dp.sv
// ----------------------------------------------------------------------------
// tfst_dp
// Datapath of the flow table: input capture, protocol register, fill count,
// entry memory with registered read, key compare, saturating counters and
// the output register.
// ----------------------------------------------------------------------------
module tfst_dp import tfst_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [PROTO_W-1:0] cfg_wdata_i,
  // input payload
  input  logic               action_i,
  input  logic [PROTO_W-1:0] protocol_i,
  input  logic [IP_W-1:0]    src_ip_i,
  input  logic [IP_W-1:0]    dst_ip_i,
  input  logic [PORT_W-1:0]  src_port_i,
  input  logic [PORT_W-1:0]  dst_port_i,
  input  logic [LEN_W-1:0]   wire_length_i,
  input  logic [IDX_W-1:0]   read_index_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic [IDX_W-1:0]   flow_index_o,
  output logic [IP_W-1:0]    flow_src_ip_o,
  output logic [IP_W-1:0]    flow_dst_ip_o,
  output logic [PORT_W-1:0]  flow_src_port_o,
  output logic [PORT_W-1:0]  flow_dst_port_o,
  output logic [CTR_W-1:0]   packet_count_o,
  output logic [CTR_W-1:0]   byte_count_o,
  // controller
  input  cmd_t               cmd_i,
  output status_t            sts_o
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FLOW_ENTRIES);

  logic [PROTO_W-1:0] cfg_proto_q;
  logic [CNT_W-1:0]   used_q;
  logic [CNT_W-1:0]   addr_q;

  logic               act_q;
  logic [PROTO_W-1:0] proto_q;
  key_t               key_q;
  logic [LEN_W-1:0]   wlen_q;
  logic [IDX_W-1:0]   ridx_q;

  entry_t             mem_q [FLOW_ENTRIES];
  entry_t             rd_q;
  logic [IDX_W-1:0]   rd_idx_q;

  logic               out_valid_q;
  status_e            status_q;
  logic [IDX_W-1:0]   idx_q;
  key_t               okey_q;
  logic [CTR_W-1:0]   opkt_q;
  logic [CTR_W-1:0]   obyt_q;

  logic [IDX_W-1:0]   rd_addr;
  logic [CTR_W-1:0]   pkt_inc;
  logic [CTR_W:0]     byt_sum;
  logic [CTR_W-1:0]   byt_inc;
  entry_t             wr_entry;
  logic [IDX_W-1:0]   wr_addr;
  logic               wr_en;

  // Control registers: protocol, fill count, scan address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_proto_q <= PROTO_RESET;
      used_q      <= '0;
      addr_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        cfg_proto_q <= cfg_wdata_i;
      end
      if (cmd_i.wr_new) begin
        used_q <= used_q + CNT_W'(1);
      end
      if (cmd_i.load_in) begin
        addr_q <= '0;
      end else if (cmd_i.rd_en && !cmd_i.rd_sel_ridx) begin
        addr_q <= addr_q + CNT_W'(1);
      end
    end
  end

  // Input capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      act_q     <= action_i;
      proto_q   <= protocol_i;
      key_q     <= '{sip: src_ip_i, dip: dst_ip_i, sport: src_port_i, dport: dst_port_i};
      wlen_q    <= wire_length_i;
      ridx_q    <= read_index_i;
    end
  end

  // Saturating counter update of the registered entry
  assign pkt_inc = (&rd_q.pkt) ? rd_q.pkt : rd_q.pkt + CTR_W'(1);
  assign byt_sum = {1'b0, rd_q.byt} + (CTR_W + 1)'(wlen_q);
  assign byt_inc = byt_sum[CTR_W] ? {CTR_W{1'b1}} : byt_sum[CTR_W-1:0];

  // Memory write port
  always_comb begin
    wr_en    = cmd_i.wr_hit || cmd_i.wr_new;
    wr_addr  = used_q[IDX_W-1:0];
    wr_entry = '{key: key_q, pkt: CTR_W'(1), byt: CTR_W'(wlen_q)};
    if (cmd_i.wr_hit) begin
      wr_addr  = rd_idx_q;
      wr_entry = '{key: rd_q.key, pkt: pkt_inc, byt: byt_inc};
    end
  end

  assign rd_addr = cmd_i.rd_sel_ridx ? ridx_q : addr_q[IDX_W-1:0];

  // Entry memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_entry;
    end
    if (cmd_i.rd_en) begin
      rd_q     <= mem_q[rd_addr];
      rd_idx_q <= rd_addr;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_ld) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_ld) begin
      status_q <= cmd_i.res_sel;
      idx_q    <= '0;
      okey_q   <= '0;
      opkt_q   <= '0;
      obyt_q   <= '0;
      case (cmd_i.res_sel)
        ST_HIT: begin
          idx_q  <= rd_idx_q;
          okey_q <= rd_q.key;
          opkt_q <= pkt_inc;
          obyt_q <= byt_inc;
        end
        ST_NEW: begin
          idx_q  <= used_q[IDX_W-1:0];
          okey_q <= key_q;
          opkt_q <= CTR_W'(1);
          obyt_q <= CTR_W'(wlen_q);
        end
        ST_FULL: begin
          okey_q <= key_q;
        end
        ST_READ_OK: begin
          idx_q  <= rd_idx_q;
          okey_q <= rd_q.key;
          opkt_q <= rd_q.pkt;
          obyt_q <= rd_q.byt;
        end
        ST_READ_EMPTY: begin
          idx_q <= ridx_q;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign flow_index_o    = idx_q;
  assign flow_src_ip_o   = okey_q.sip;
  assign flow_dst_ip_o   = okey_q.dip;
  assign flow_src_port_o = okey_q.sport;
  assign flow_dst_port_o = okey_q.dport;
  assign packet_count_o  = opkt_q;
  assign byte_count_o    = obyt_q;

  // Status toward the controller
  assign sts_o.act_read    = (act_q == ACT_READ);
  assign sts_o.proto_match = (proto_q == cfg_proto_q);
  assign sts_o.ridx_valid  = ({1'b0, ridx_q} < used_q);
  assign sts_o.scan_end    = (addr_q == used_q);
  assign sts_o.key_match   = (rd_q.key == key_q);
  assign sts_o.full        = (used_q == FULL_CNT);
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

endmodule

// File: design/tcp_flow_stats_table_unit.sv
// ----------------------------------------------------------------------------
// tcp_flow_stats_table_unit
// Per-flow packet and byte statistics table with in-order allocation,
// saturating counters and entry read-back.
// ----------------------------------------------------------------------------
//  Channel  | Handshake                    | Payload
//  ---------+------------------------------+----------------------------------
//  input    | in_valid_i / in_stall_o      | action, protocol, key, length,
//           |                              | read_index
//  output   | out_valid_o / out_stall_i    | status, flow_index, key, counts
//  config   | cfg_we_i                     | cfg_wdata_i (counted protocol)
//
//  One transfer at a time. Ignored packets and empty reads are answered from
//  the decode state, valid reads after one table read, counted packets after
//  a linear search that reads one table entry per cycle from the entry memory.
//  Reset empties the table at once through the fill count; no clearing pass.
//  A stalled result waits in the output register; the next transfer is
//  taken meanwhile and finishes once the output register frees up.
// ----------------------------------------------------------------------------
module tcp_flow_stats_table_unit import tfst_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [PROTO_W-1:0] cfg_wdata_i,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               action_i,
  input  logic [PROTO_W-1:0] protocol_i,
  input  logic [IP_W-1:0]    src_ip_i,
  input  logic [IP_W-1:0]    dst_ip_i,
  input  logic [PORT_W-1:0]  src_port_i,
  input  logic [PORT_W-1:0]  dst_port_i,
  input  logic [LEN_W-1:0]   wire_length_i,
  input  logic [IDX_W-1:0]   read_index_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic [IDX_W-1:0]   flow_index_o,
  output logic [IP_W-1:0]    flow_src_ip_o,
  output logic [IP_W-1:0]    flow_dst_ip_o,
  output logic [PORT_W-1:0]  flow_src_port_o,
  output logic [PORT_W-1:0]  flow_dst_port_o,
  output logic [CTR_W-1:0]   packet_count_o,
  output logic [CTR_W-1:0]   byte_count_o
);

  cmd_t    cmd;
  status_t sts;

  // Sequencer
  tfst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Table and result datapath
  tfst_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .action_i        (action_i),
    .protocol_i      (protocol_i),
    .src_ip_i        (src_ip_i),
    .dst_ip_i        (dst_ip_i),
    .src_port_i      (src_port_i),
    .dst_port_i      (dst_port_i),
    .wire_length_i   (wire_length_i),
    .read_index_i    (read_index_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .flow_index_o    (flow_index_o),
    .flow_src_ip_o   (flow_src_ip_o),
    .flow_dst_ip_o   (flow_dst_ip_o),
    .flow_src_port_o (flow_src_port_o),
    .flow_dst_port_o (flow_dst_port_o),
    .packet_count_o  (packet_count_o),
    .byte_count_o    (byte_count_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for tcp_flow_stats_table_unit. A scoreboard keeps
// its own flow table (keys, saturating counters, fill count, counted
// protocol) and predicts the result of every input transfer. Each output
// transfer is compared field by field with the oldest prediction. The run
// starts with directed descriptors and reads. Random phases follow, each
// with its own counted protocol and idle pattern on both channels. The
// random traffic fills the table and then keeps hitting and dropping flows.
// ----------------------------------------------------------------------------
module tb import tfst_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PHASE_ITEMS  = 170;
  localparam int DRAIN_CYCLES = 80;

  // One input transfer
  typedef struct packed {
    logic               action;
    logic [PROTO_W-1:0] protocol;
    key_t               key;
    logic [LEN_W-1:0]   wire_length;
    logic [IDX_W-1:0]   read_index;
  } flow_desc_t;

  // One output transfer
  typedef struct packed {
    status_e            status;
    logic [IDX_W-1:0]   flow_index;
    key_t               key;
    logic [CTR_W-1:0]   pkt;
    logic [CTR_W-1:0]   byt;
  } flow_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: flow table predictor plus queue of expected results
  // --------------------------------------------------------------------------
  class flow_stats_scoreboard;
    logic [PROTO_W-1:0] counted_protocol;
    int unsigned        fill_count;
    key_t               flow_keys[FLOW_ENTRIES];
    logic [CTR_W-1:0]   pkt_ctr[FLOW_ENTRIES];
    logic [CTR_W-1:0]   byte_ctr[FLOW_ENTRIES];
    flow_result_t       pending_flow_results[$];
    int unsigned        mismatches;

    function new();
      counted_protocol = PROTO_RESET;
      fill_count       = 0;
      mismatches       = 0;
    endfunction

    function logic [CTR_W-1:0] sat_add(logic [CTR_W-1:0] a, logic [CTR_W-1:0] b);
      logic [CTR_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[CTR_W] ? {CTR_W{1'b1}} : sum[CTR_W-1:0];
    endfunction

    function flow_result_t predict_flow_result(flow_desc_t d);
      flow_result_t r;
      int unsigned  i;
      r = '0;
      // read-back ignores all packet fields
      if (d.action == ACT_READ) begin
        r.flow_index = d.read_index;
        if (d.read_index < fill_count) begin
          r.status = ST_READ_OK;
          r.key    = flow_keys[d.read_index];
          r.pkt    = pkt_ctr[d.read_index];
          r.byt    = byte_ctr[d.read_index];
        end else begin
          r.status = ST_READ_EMPTY;
        end
        return r;
      end
      if (d.protocol != counted_protocol) begin
        r.status = ST_IGNORED;
        return r;
      end
      // linear search over allocated entries
      for (i = 0; i < fill_count; i++) begin
        if (flow_keys[i] == d.key) begin
          pkt_ctr[i]   = sat_add(pkt_ctr[i], 1);
          byte_ctr[i]  = sat_add(byte_ctr[i], CTR_W'(d.wire_length));
          r.status     = ST_HIT;
          r.flow_index = IDX_W'(i);
          r.key        = flow_keys[i];
          r.pkt        = pkt_ctr[i];
          r.byt        = byte_ctr[i];
          return r;
        end
      end
      // miss with no room: drop, echo the key
      if (fill_count >= FLOW_ENTRIES) begin
        r.status = ST_FULL;
        r.key    = d.key;
        return r;
      end
      flow_keys[fill_count] = d.key;
      pkt_ctr[fill_count]   = 1;
      byte_ctr[fill_count]  = CTR_W'(d.wire_length);
      r.status              = ST_NEW;
      r.flow_index          = IDX_W'(fill_count);
      r.key                 = d.key;
      r.pkt                 = 1;
      r.byt                 = CTR_W'(d.wire_length);
      fill_count++;
      return r;
    endfunction

    function void note_descriptor(flow_desc_t d);
      pending_flow_results.push_back(predict_flow_result(d));
    endfunction

    function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (exp_val !== act_val) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
        mismatches++;
      end
    endfunction

    function void check_result(flow_result_t got);
      flow_result_t exp_r;
      if (pending_flow_results.size() == 0) begin
        $error("result transfer with no expected result, status %0d", got.status);
        mismatches++;
        return;
      end
      exp_r = pending_flow_results.pop_front();
      compare_field("status", 32'(exp_r.status), 32'(got.status));
      compare_field("flow_index", 32'(exp_r.flow_index), 32'(got.flow_index));
      compare_field("flow_src_ip", exp_r.key.sip, got.key.sip);
      compare_field("flow_dst_ip", exp_r.key.dip, got.key.dip);
      compare_field("flow_src_port", 32'(exp_r.key.sport), 32'(got.key.sport));
      compare_field("flow_dst_port", 32'(exp_r.key.dport), 32'(got.key.dport));
      compare_field("packet_count", exp_r.pkt, got.pkt);
      compare_field("byte_count", exp_r.byt, got.byt);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT signals
  // --------------------------------------------------------------------------
  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               cfg_we_i        = 1'b0;
  logic [PROTO_W-1:0] cfg_wdata_i     = PROTO_RESET;
  logic               in_valid_i      = 1'b0;
  logic               in_stall_o;
  logic               action_i        = ACT_COUNT;
  logic [PROTO_W-1:0] protocol_i      = '0;
  logic [IP_W-1:0]    src_ip_i        = '0;
  logic [IP_W-1:0]    dst_ip_i        = '0;
  logic [PORT_W-1:0]  src_port_i      = '0;
  logic [PORT_W-1:0]  dst_port_i      = '0;
  logic [LEN_W-1:0]   wire_length_i   = '0;
  logic [IDX_W-1:0]   read_index_i    = '0;
  logic               out_valid_o;
  logic               out_stall_i     = 1'b0;
  logic [2:0]         status_o;
  logic [IDX_W-1:0]   flow_index_o;
  logic [IP_W-1:0]    flow_src_ip_o;
  logic [IP_W-1:0]    flow_dst_ip_o;
  logic [PORT_W-1:0]  flow_src_port_o;
  logic [PORT_W-1:0]  flow_dst_port_o;
  logic [CTR_W-1:0]   packet_count_o;
  logic [CTR_W-1:0]   byte_count_o;

  flow_stats_scoreboard sb = new();
  key_t                 known_keys[$];
  int unsigned          send_idle_pct  = 0;
  int unsigned          recv_stall_pct = 0;
  int unsigned          cycle_count    = 0;

  tcp_flow_stats_table_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .protocol_i      (protocol_i),
    .src_ip_i        (src_ip_i),
    .dst_ip_i        (dst_ip_i),
    .src_port_i      (src_port_i),
    .dst_port_i      (dst_port_i),
    .wire_length_i   (wire_length_i),
    .read_index_i    (read_index_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .flow_index_o    (flow_index_o),
    .flow_src_ip_o   (flow_src_ip_o),
    .flow_dst_ip_o   (flow_dst_ip_o),
    .flow_src_port_o (flow_src_port_o),
    .flow_dst_port_o (flow_dst_port_o),
    .packet_count_o  (packet_count_o),
    .byte_count_o    (byte_count_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: check each transfer, stall at random
  always @(posedge clk_i) begin
    flow_result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.status     = status_e'(status_o);
      got.flow_index = flow_index_o;
      got.key.sip    = flow_src_ip_o;
      got.key.dip    = flow_dst_ip_o;
      got.key.sport  = flow_src_port_o;
      got.key.dport  = flow_dst_port_o;
      got.pkt        = packet_count_o;
      got.byt        = byte_count_o;
      sb.check_result(got);
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Descriptor builders
  // --------------------------------------------------------------------------
  function key_t random_key();
    return key_t'{$urandom, $urandom, PORT_W'($urandom), PORT_W'($urandom)};
  endfunction

  function flow_desc_t count_desc(logic [PROTO_W-1:0] proto, key_t k, logic [LEN_W-1:0] len);
    flow_desc_t d;
    d.action      = ACT_COUNT;
    d.protocol    = proto;
    d.key         = k;
    d.wire_length = len;
    d.read_index  = IDX_W'($urandom);
    return d;
  endfunction

  // packet fields of a read carry junk on purpose
  function flow_desc_t read_desc(logic [IDX_W-1:0] idx);
    flow_desc_t d;
    d.action      = ACT_READ;
    d.protocol    = PROTO_W'($urandom);
    d.key         = random_key();
    d.wire_length = LEN_W'($urandom);
    d.read_index  = idx;
    return d;
  endfunction

  function logic [LEN_W-1:0] random_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return LEN_W'($urandom_range(65535));
  endfunction

  // Mostly counted packets on a growing key pool, some near-miss keys,
  // some reads and some foreign protocols
  function flow_desc_t random_desc();
    int unsigned r;
    key_t        k;
    r = $urandom_range(99);
    if (r < 12) return read_desc(IDX_W'($urandom_range(FLOW_ENTRIES - 1)));
    if (r < 20) return count_desc(PROTO_W'($urandom), random_key(), random_length());
    r = $urandom_range(99);
    if (known_keys.size() == 0 || r < 20) begin
      k = random_key();
      known_keys.push_back(k);
    end else begin
      k = known_keys[$urandom_range(known_keys.size() - 1)];
      if (r < 28) begin
        case ($urandom_range(3))
          0:       k.sip   ^= 32'd1 << $urandom_range(31);
          1:       k.dip   ^= 32'd1 << $urandom_range(31);
          2:       k.sport ^= 16'd1 << $urandom_range(15);
          default: k.dport ^= 16'd1 << $urandom_range(15);
        endcase
      end
    end
    return count_desc(sb.counted_protocol, k, random_length());
  endfunction

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------
  task automatic send_descriptor(flow_desc_t d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= d.action;
    protocol_i    <= d.protocol;
    src_ip_i      <= d.key.sip;
    dst_ip_i      <= d.key.dip;
    src_port_i    <= d.key.sport;
    dst_port_i    <= d.key.dport;
    wire_length_i <= d.wire_length;
    read_index_i  <= d.read_index;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_descriptor(d);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending_flow_results.size() != 0) @(posedge clk_i);
  endtask

  // register write only with the block idle
  task automatic set_counted_protocol(logic [PROTO_W-1:0] proto);
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= proto;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.counted_protocol = proto;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [PROTO_W-1:0] phase_proto[5];
    int unsigned        phase_idle[5];
    int unsigned        phase_stall[5];
    int                 p;
    int                 n;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, counted protocol still at its reset value
    send_descriptor(read_desc(IDX_W'(0)));
    send_descriptor(read_desc(IDX_W'(FLOW_ENTRIES - 1)));
    send_descriptor(count_desc(8'd17, random_key(), random_length()));
    send_descriptor(count_desc(8'd0, random_key(), random_length()));
    send_descriptor(count_desc(8'd255, random_key(), random_length()));
    send_descriptor(count_desc(PROTO_RESET, key_t'{32'h0, 32'h0, 16'h0, 16'h0}, 16'h0000));
    send_descriptor(count_desc(PROTO_RESET, key_t'{32'h0, 32'h0, 16'h0, 16'h0}, 16'hFFFF));
    send_descriptor(count_desc(PROTO_RESET, key_t'{'1, '1, '1, '1}, 16'hFFFF));
    send_descriptor(count_desc(PROTO_RESET, key_t'{'1, '1, '1, '1}, 16'h0001));
    // keys that differ from the zero key in one field only
    send_descriptor(count_desc(PROTO_RESET, key_t'{32'h0, 32'h0, 16'h1, 16'h0}, 16'h0040));
    send_descriptor(count_desc(PROTO_RESET, key_t'{32'h0, 32'h0, 16'h0, 16'h8000}, 16'h05DC));
    send_descriptor(count_desc(PROTO_RESET, key_t'{32'h80000000, 32'h0, 16'h0, 16'h0}, 16'h0));
    send_descriptor(count_desc(PROTO_RESET, key_t'{32'h0, 32'h1, 16'h0, 16'h0}, 16'h7FFF));
    for (n = 0; n <= 6; n++) send_descriptor(read_desc(IDX_W'(n)));
    send_descriptor(read_desc(IDX_W'(FLOW_ENTRIES - 1)));

    // Random phases: counted protocol and idle pattern per phase
    phase_proto = '{PROTO_RESET, 8'd0, 8'd255, PROTO_RESET, PROTO_W'($urandom)};
    phase_idle  = '{0, 61, 0, 30, 0};
    phase_stall = '{0, 0, 61, 30, 0};
    for (p = 0; p < 5; p++) begin
      set_counted_protocol(phase_proto[p]);
      send_idle_pct  = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      for (n = 0; n < PHASE_ITEMS; n++) send_descriptor(random_desc());
    end

    // Drain and finish
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
design/tfst_pkg.sv
design/tfst_ctrl.sv
design/tfst_dp.sv
design/tcp_flow_stats_table_unit.sv
sim/tb.sv
